// ----- src/asgr_pkg.sv -----
package asgr_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned NumW   = 8;
  localparam int unsigned ColorW = 3;
  localparam int unsigned FgW    = 4;

  localparam logic [CharW-1:0] ChEsc      = 16'h001B;
  localparam logic [CharW-1:0] ChLBracket = 16'h005B;
  localparam logic [CharW-1:0] ChM        = 16'h006D;
  localparam logic [CharW-1:0] ChZero     = 16'h0030;
  localparam logic [CharW-1:0] ChNine     = 16'h0039;

  localparam logic [NumW-1:0] NumMax     = 8'd255;
  localparam logic [NumW-1:0] SgrReset   = 8'd0;
  localparam logic [NumW-1:0] SgrBold    = 8'd1;
  localparam logic [NumW-1:0] SgrFgFirst = 8'd30;
  localparam logic [NumW-1:0] SgrFgLast  = 8'd37;
  localparam logic [NumW-1:0] SgrBgFirst = 8'd40;
  localparam logic [NumW-1:0] SgrBgLast  = 8'd47;

  localparam logic [ColorW-1:0] FgDefault = 3'd7;
  localparam logic [ColorW-1:0] BgDefault = 3'd0;

  // Configuration register indexes.
  localparam logic CfgDarkOnly   = 1'b0;
  localparam logic CfgShowHidden = 1'b1;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic [FgW-1:0]    fg_index;
    logic [ColorW-1:0] bg_index;
    logic              hidden_mark;
  } asgr_res_t;

endpackage

// ----- src/asgr_core.sv -----
module asgr_core import asgr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             line_start_i,
  input  logic             dark_only_i,
  input  logic             show_hidden_i,
  output logic             emit_o,
  output asgr_res_t        res_o
);

  mode_e             mode_q, mode_d;
  logic [NumW-1:0]   num_q, num_d;
  logic              seen_q, seen_d;
  logic [ColorW-1:0] fore_q, fore_d;
  logic [ColorW-1:0] back_q, back_d;
  logic              bold_q, bold_d;

  // State as seen by this character, after an optional line reset.
  mode_e             mode_c;
  logic [NumW-1:0]   num_c;
  logic              seen_c;
  logic [ColorW-1:0] fore_c;
  logic [ColorW-1:0] back_c;
  logic              bold_c;

  logic              is_digit;
  logic [NumW+3:0]   num_acc;
  logic [NumW-1:0]   fg_off;
  logic [FgW-1:0]    fg;

  always_comb begin
    if (line_start_i) begin
      mode_c = MODE_TEXT;
      num_c  = '0;
      seen_c = 1'b0;
      fore_c = FgDefault;
      back_c = BgDefault;
      bold_c = 1'b0;
    end else begin
      mode_c = mode_q;
      num_c  = num_q;
      seen_c = seen_q;
      fore_c = fore_q;
      back_c = back_q;
      bold_c = bold_q;
    end
  end

  assign is_digit = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign num_acc  = ({4'd0, num_c} * (NumW+4)'(10)) + (NumW+4)'(char_code_i[3:0]);
  assign fg_off   = num_c - SgrFgFirst;

  always_comb begin
    mode_d = mode_c;
    num_d  = num_c;
    seen_d = seen_c;
    fore_d = fore_c;
    back_d = back_c;
    bold_d = bold_c;
    emit_o = 1'b0;
    case (mode_c)
      MODE_ESC: begin
        if (char_code_i == ChLBracket) begin
          mode_d = MODE_PARAM;
          num_d  = '0;
          seen_d = 1'b0;
        end else if (char_code_i == ChM) begin
          mode_d = MODE_TEXT;
        end else begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (char_code_i == ChM) begin
          mode_d = MODE_TEXT;
        end
      end
      MODE_PARAM: begin
        if (is_digit) begin
          num_d  = (num_acc > {4'd0, NumMax}) ? NumMax : num_acc[NumW-1:0];
          seen_d = 1'b1;
        end else begin
          // Any non-digit closes the current parameter and applies it.
          if (seen_c) begin
            if (num_c == SgrReset) begin
              fore_d = FgDefault;
              back_d = BgDefault;
              bold_d = 1'b0;
            end else if (num_c == SgrBold) begin
              bold_d = 1'b1;
            end else if (num_c >= SgrFgFirst && num_c <= SgrFgLast) begin
              fore_d = fg_off[ColorW-1:0];
            end else if (num_c >= SgrBgFirst && num_c <= SgrBgLast) begin
              back_d = num_c[ColorW-1:0];
            end
          end
          num_d  = '0;
          seen_d = 1'b0;
          if (char_code_i == ChM) begin
            mode_d = MODE_TEXT;
          end
        end
      end
      default: begin
        if (char_code_i == ChEsc) begin
          mode_d = MODE_ESC;
        end else begin
          emit_o = 1'b1;
        end
      end
    endcase
  end

  assign fg = {bold_c & ~dark_only_i, fore_c};

  always_comb begin
    res_o.out_char    = char_code_i;
    res_o.fg_index    = fg;
    res_o.bg_index    = back_c;
    res_o.hidden_mark = show_hidden_i && (fg == {1'b0, back_c});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      num_q  <= '0;
      seen_q <= 1'b0;
      fore_q <= FgDefault;
      back_q <= BgDefault;
      bold_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      num_q  <= num_d;
      seen_q <= seen_d;
      fore_q <= fore_d;
      back_q <= back_d;
      bold_q <= bold_d;
    end
  end

endmodule

// ----- src/asgr_out_reg.sv -----
module asgr_out_reg import asgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  asgr_res_t res_i,
  output logic      free_o,
  output logic      valid_o,
  input  logic      ready_i,
  output asgr_res_t res_o
);

  logic      valid_q, valid_d;
  asgr_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- src/ansi_sgr_color_parser.sv -----
// ANSI SGR color parser: strips escape sequences from a stream of 16-bit
// characters and tags every displayable character with its palette indexes.
// Input channel (s_axis_*): one character per word, tuser carries the
// line-start flag, which resets the attributes and the parser before that
// character is handled. Output channel (m_axis_*): one word per displayable
// character; ESC and all characters of a sequence give no word.
// Configuration channel (cfg_*): index 0 is dark_only, index 1 is
// show_hidden; it is always ready and should be written while idle.
// An accepted word waits in the input register until the output register
// is free; it is then parsed in a single combinational pass, and the result
// word, if the character is displayable, is loaded into the output register.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single combinational parse between the two registers.
// When the receiver stalls, the output register holds its word; the input
// register still takes one more word, and then tready drops until the
// output register frees up. Reset empties both registers, returns the parser
// to text mode with foreground 7, background 0, bold off, and clears both
// configuration bits.
module ansi_sgr_color_parser import asgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] line_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] out_char, [19:16] fg_index,
                                      // [22:20] bg_index, [23] zero
  output logic [0:0]  m_axis_tuser,   // [0] hidden_mark
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             in_ls_q;
  logic             dark_only_q, show_hidden_q;
  logic             in_accept, step, out_free, emit;
  asgr_res_t        core_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_only_q   <= 1'b0;
      show_hidden_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDarkOnly:   dark_only_q   <= cfg_data_i;
        CfgShowHidden: show_hidden_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_accept || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_char_q <= s_axis_tdata;
      in_ls_q   <= s_axis_tuser[0];
    end
  end

  asgr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .char_code_i   (in_char_q),
    .line_start_i  (in_ls_q),
    .dark_only_i   (dark_only_q),
    .show_hidden_i (show_hidden_q),
    .emit_o        (emit),
    .res_o         (core_res)
  );

  asgr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && emit),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.bg_index, out_res.fg_index, out_res.out_char};
  assign m_axis_tuser = out_res.hidden_mark;

endmodule
